### hdl/pbme_pkg.sv
`timescale 1ns / 1ps

package pbme_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_W         = 16;
    localparam int BLK_W          = 11;
    localparam int DIV_W          = 64;
    localparam int ROOT_W         = 32;
    localparam int MAX_BLOCKS_DEF = 1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_MUL,
        ST_MSQ_GO,
        ST_MSQ_WAIT,
        ST_VAR_CHK,
        ST_VAR_GO,
        ST_VAR_WAIT,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_MSQ,
        DIV_VAR
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_mean;
        logic     mul_en;
        logic     cap_msq;
        logic     sqrt_start;
        logic     cap_err;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic multi;
        logic diff_pos;
    } sts_t;

endpackage

### hdl/pbme_div.sv
`timescale 1ns / 1ps

module pbme_div #(
    parameter int DW = 64,
    parameter int VW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int CNT_W = $clog2(DW);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VW-1:0]    rem_reg, rem_next;
    logic [VW-1:0]    dvs_reg, dvs_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [VW:0]      rem_sh;
    logic [VW:0]      rem_sub;
    logic             ge;

    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### hdl/pbme_sqrt.sv
`timescale 1ns / 1ps

module pbme_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pbme_pkg::DIV_W-1:0]  value,
    output logic                        done,
    output logic [pbme_pkg::ROOT_W-1:0] root
);
    import pbme_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [DIV_W-1:0]  val_reg, val_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], val_reg[DIV_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        ge        = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            root_next = '0;
            val_next  = value;
        end else if (busy_reg) begin
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            val_next  = {val_reg[DIV_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### hdl/pbme_dp.sv
`timescale 1ns / 1ps

module pbme_dp #(
    parameter int MAX_BLOCKS = pbme_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pbme_pkg::cmd_t              cmd,
    output pbme_pkg::sts_t              sts,
    input  logic signed [pbme_pkg::DATA_W-1:0] s_block_mean,
    input  logic [pbme_pkg::DATA_W-1:0] s_block_mean_square,
    input  logic                        s_start_series,
    output logic signed [pbme_pkg::DATA_W-1:0] m_running_mean,
    output logic [pbme_pkg::DATA_W-1:0] m_running_error,
    output logic [pbme_pkg::BLK_W-1:0]  m_blocks_used,
    output logic                        m_series_full
);
    import pbme_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int SW = DATA_W + CW;

    logic [CW-1:0]            count_reg, count_next, cnt_base;
    logic signed [SW-1:0]     sum_m_reg, sum_m_next, sm_base;
    logic [SW-1:0]            sum_s_reg, sum_s_next, ss_base;
    logic                     full_reg, full_next, is_full;
    logic signed [DATA_W-1:0] mean_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic [DATA_W-1:0]        msq_reg;
    logic [DIV_W-1:0]         sq_reg;
    logic [ROOT_W-1:0]        err_reg;
    logic [SW-1:0]            mag_m;
    logic [CW-1:0]            half;
    logic [DIV_W-1:0]         msq_sh, diff;
    logic [DIV_W-1:0]         div_dvd;
    logic [CW-1:0]            div_dvs;
    logic                     div_done, sqrt_done;
    logic [DIV_W-1:0]         quo;
    logic [ROOT_W-1:0]        root;

    always_comb begin
        cnt_base   = s_start_series ? '0 : count_reg;
        sm_base    = s_start_series ? '0 : sum_m_reg;
        ss_base    = s_start_series ? '0 : sum_s_reg;
        is_full    = cnt_base >= CW'(MAX_BLOCKS);
        count_next = is_full ? cnt_base : cnt_base + 1'b1;
        sum_m_next = is_full ? sm_base
                             : sm_base + SW'(s_block_mean);
        sum_s_next = is_full ? ss_base
                             : ss_base + SW'(s_block_mean_square);
        full_next  = is_full;

        mag_m  = sum_m_reg[SW-1] ? SW'(-sum_m_reg) : SW'(sum_m_reg);
        half   = count_reg >> 1;
        msq_sh = {{(DIV_W-DATA_W-FRAC_W){1'b0}}, msq_reg, {FRAC_W{1'b0}}};
        diff   = msq_sh - sq_reg;

        case (cmd.div_sel)
            DIV_MEAN: begin
                div_dvd = DIV_W'(mag_m) + DIV_W'(half);
                div_dvs = count_reg;
            end
            DIV_MSQ: begin
                div_dvd = DIV_W'(sum_s_reg) + DIV_W'(half);
                div_dvs = count_reg;
            end
            DIV_VAR: begin
                div_dvd = diff;
                div_dvs = count_reg - 1'b1;
            end
            default: begin
                div_dvd = '0;
                div_dvs = count_reg;
            end
        endcase
    end

    pbme_div #(
        .DW(DIV_W),
        .VW(CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (quo)
    );

    pbme_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .value   (quo),
        .done    (sqrt_done),
        .root    (root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            sum_m_reg <= '0;
            sum_s_reg <= '0;
            full_reg  <= 1'b0;
        end else if (cmd.accept) begin
            count_reg <= count_next;
            sum_m_reg <= sum_m_next;
            sum_s_reg <= sum_s_next;
            full_reg  <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            err_reg <= '0;
        end else if (cmd.cap_err) begin
            err_reg <= root;
        end
        if (cmd.cap_mean) begin
            mag_reg  <= quo[DATA_W-1:0];
            mean_reg <= sum_m_reg[SW-1] ? -$signed(quo[DATA_W-1:0])
                                        : $signed(quo[DATA_W-1:0]);
        end
        if (cmd.mul_en) begin
            sq_reg <= DIV_W'(mag_reg) * DIV_W'(mag_reg);
        end
        if (cmd.cap_msq) begin
            msq_reg <= quo[DATA_W-1:0];
        end
        if (cmd.load_out) begin
            m_running_mean  <= mean_reg;
            m_running_error <= DATA_W'(err_reg);
            m_blocks_used   <= BLK_W'(count_reg);
            m_series_full   <= full_reg;
        end
    end

    assign sts.div_done  = div_done;
    assign sts.sqrt_done = sqrt_done;
    assign sts.multi     = count_reg > CW'(1);
    assign sts.diff_pos  = msq_sh > sq_reg;

endmodule

### hdl/pbme_ctrl.sv
`timescale 1ns / 1ps

module pbme_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output pbme_pkg::cmd_t cmd,
    input  pbme_pkg::sts_t sts
);
    import pbme_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   slot_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MEAN;
        s_ready    = 1'b0;
        slot_free  = !m_valid_reg || m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (sts.div_done) begin
                    cmd.cap_mean = 1'b1;
                    state_next   = sts.multi ? ST_MUL : ST_RESULT;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_MSQ_GO;
            end
            ST_MSQ_GO: begin
                cmd.div_sel   = DIV_MSQ;
                cmd.div_start = 1'b1;
                state_next    = ST_MSQ_WAIT;
            end
            ST_MSQ_WAIT: begin
                cmd.div_sel = DIV_MSQ;
                if (sts.div_done) begin
                    cmd.cap_msq = 1'b1;
                    state_next  = ST_VAR_CHK;
                end
            end
            ST_VAR_CHK: begin
                state_next = sts.diff_pos ? ST_VAR_GO : ST_RESULT;
            end
            ST_VAR_GO: begin
                cmd.div_sel   = DIV_VAR;
                cmd.div_start = 1'b1;
                state_next    = ST_VAR_WAIT;
            end
            ST_VAR_WAIT: begin
                cmd.div_sel = DIV_VAR;
                if (sts.div_done) begin
                    state_next = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                cmd.sqrt_start = 1'b1;
                state_next     = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sts.sqrt_done) begin
                    cmd.cap_err = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/progressive_block_mean_error.sv
`timescale 1ns / 1ps
// channel | ports                                        | handshake
// input   | s_block_mean, s_block_mean_square, s_start_series | s_valid / s_ready
// result  | m_running_mean, m_running_error, m_blocks_used, m_series_full | m_valid / m_ready
//
// One item at a time: the mean division always; when the count exceeds one, the multiply,
// mean-square division and variance check; if the variance is positive, the variance
// division and square root. The divider is shared and 64-step radix-2, the root 32-step;
// each pass runs a start state, its steps and a wait for done.
// Synchronous active-low reset clears count, sums and control; no clearing pass.
// A result waits in the output register; the next item is taken meanwhile and is held
// only at the end of its work if the previous result has not been taken.
module progressive_block_mean_error #(
    parameter int MAX_BLOCKS = pbme_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pbme_pkg::DATA_W-1:0] s_block_mean,
    input  logic [pbme_pkg::DATA_W-1:0]        s_block_mean_square,
    input  logic                               s_start_series,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pbme_pkg::DATA_W-1:0] m_running_mean,
    output logic [pbme_pkg::DATA_W-1:0]        m_running_error,
    output logic [pbme_pkg::BLK_W-1:0]         m_blocks_used,
    output logic                               m_series_full
);
    import pbme_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pbme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    pbme_dp #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cmd                 (cmd),
        .sts                 (sts),
        .s_block_mean        (s_block_mean),
        .s_block_mean_square (s_block_mean_square),
        .s_start_series      (s_start_series),
        .m_running_mean      (m_running_mean),
        .m_running_error     (m_running_error),
        .m_blocks_used       (m_blocks_used),
        .m_series_full       (m_series_full)
    );

endmodule

### hdl/pbme_checker.sv
`timescale 1ns / 1ps

module pbme_checker #(
    parameter int MAX_BLOCKS = pbme_pkg::MAX_BLOCKS_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [pbme_pkg::DATA_W-1:0]        m_running_mean,
    input logic [pbme_pkg::DATA_W-1:0]        m_running_error,
    input logic [pbme_pkg::BLK_W-1:0]         m_blocks_used,
    input logic                               m_series_full
);
    import pbme_pkg::*;

    a_busy_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in work");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_series_full) |-> (m_blocks_used == BLK_W'(MAX_BLOCKS)))
        else $error("full flag with count below maximum");

    a_first_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blocks_used == BLK_W'(1)) |-> (m_running_error == '0))
        else $error("nonzero error for first block");

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

    a_mean_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_running_mean))
        else $error("stalled result changed");

endmodule

bind progressive_block_mean_error pbme_checker #(
    .MAX_BLOCKS(MAX_BLOCKS)
) u_pbme_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_running_mean  (m_running_mean),
    .m_running_error (m_running_error),
    .m_blocks_used   (m_blocks_used),
    .m_series_full   (m_series_full)
);

### bench/progressive_block_mean_error_tb.sv
`timescale 1ns / 1ps

module progressive_block_mean_error_tb;
    import pbme_pkg::*;

    localparam int MAX_BLOCKS = MAX_BLOCKS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic signed [DATA_W-1:0] mean;
        logic [DATA_W-1:0]        err;
        logic [BLK_W-1:0]         used;
        logic                     full;
    } stats_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic signed [DATA_W-1:0]  s_block_mean;
    logic [DATA_W-1:0]         s_block_mean_square;
    logic                      s_start_series;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [DATA_W-1:0]  m_running_mean;
    logic [DATA_W-1:0]         m_running_error;
    logic [BLK_W-1:0]          m_blocks_used;
    logic                      m_series_full;

    stats_t   expected_stats[$];
    int       fail_count;
    int       idle_cycles;
    int       burst_left;
    int       stall_left;
    int       run_left;
    int       held_blocks;
    longint   mean_sum;
    longint unsigned square_sum;

    progressive_block_mean_error #(.MAX_BLOCKS(MAX_BLOCKS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_block_mean(s_block_mean), .s_block_mean_square(s_block_mean_square),
        .s_start_series(s_start_series),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_running_mean(m_running_mean), .m_running_error(m_running_error),
        .m_blocks_used(m_blocks_used), .m_series_full(m_series_full)
    );

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic stats_t update_stats(logic signed [DATA_W-1:0] bmean,
                                            logic [DATA_W-1:0] bsq, logic start);
        stats_t          r;
        longint          mean;
        longint unsigned mag;
        longint unsigned msq;
        longint          diff;
        r.full = 1'b0;
        mean = 0;
        r.err = '0;
        if (start) begin
            held_blocks = 0;
            mean_sum = 0;
            square_sum = 0;
        end
        if (held_blocks >= MAX_BLOCKS) begin
            r.full = 1'b1;
        end else begin
            mean_sum += longint'(bmean);
            square_sum += longint'({32'd0, bsq});
            held_blocks++;
        end
        if (held_blocks != 0) begin
            mag = (mean_sum < 0) ? -mean_sum : mean_sum;
            mag = (mag + held_blocks / 2) / held_blocks;
            mean = (mean_sum < 0) ? -longint'(mag) : longint'(mag);
            if (held_blocks > 1) begin
                msq = (square_sum + held_blocks / 2) / held_blocks;
                diff = longint'(msq << 16) - mean * mean;
                if (diff > 0)
                    r.err = DATA_W'(int_sqrt(longint'(unsigned'(diff)) /
                                             longint'(held_blocks - 1)));
            end
        end
        r.mean = DATA_W'(mean);
        r.used = BLK_W'(held_blocks);
        return r;
    endfunction

    task automatic send_block(logic signed [DATA_W-1:0] bmean, logic [DATA_W-1:0] bsq,
                              logic start);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_block_mean <= bmean;
        s_block_mean_square <= bsq;
        s_start_series <= start;
        do @(posedge aclk); while (!s_ready);
        expected_stats.push_back(update_stats(bmean, bsq, start));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 40)) @(negedge aclk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] rand_mean();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic test_directed();
        send_block(32'sh0001_0000, 32'h0001_0000, 1'b1);
        send_block(32'sh0003_0000, 32'h000A_0000, 1'b0);
        send_block(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(-32'sh8000_0000, 32'h0000_0000, 1'b0);
        send_block(32'sh0000_0000, 32'hFFFF_FFFF, 1'b1);
        send_block(32'sh0000_0000, 32'h0000_0000, 1'b0);
        send_block(-32'sh8000_0000, 32'h0000_0000, 1'b1);
        send_block(-32'sh8000_0000, 32'h0000_0000, 1'b0);
        send_block(32'sh7FFF_FFFF, 32'h0000_0000, 1'b0);
        send_block(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_block(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_block(-32'sh0000_0001, 32'h0000_0001, 1'b1);
        send_block(32'sh0000_0001, 32'h0000_0001, 1'b0);
        send_block(32'sh0000_0002, 32'h0000_0003, 1'b0);
        send_block(32'sh5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_block(-32'sh5555_5556, 32'h5555_5555, 1'b0);
        send_block(32'sh0002_0000, 32'h0000_0001, 1'b0);
        send_block(32'sh0000_8000, 32'h8000_0000, 1'b1);
        send_block(32'sh0000_8000, 32'h8000_0000, 1'b0);
        send_block(32'sh0000_8001, 32'h7FFF_FFFF, 1'b0);
    endtask

    task automatic test_series_full();
        send_block(rand_mean(), $urandom, 1'b1);
        repeat (MAX_BLOCKS + 5) send_block(rand_mean(), $urandom, 1'b0);
        send_block(rand_mean(), $urandom, 1'b1);
        send_block(rand_mean(), $urandom, 1'b0);
    endtask

    task automatic test_random_series();
        repeat (300) begin
            if (run_left == 0) begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
                send_block(rand_mean(), $urandom, 1'b1);
            end else begin
                run_left--;
                send_block(rand_mean(), $urandom, ($urandom_range(0, 30) == 0));
            end
        end
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            case ($urandom_range(0, 9))
                0: stall_left <= $urandom_range(1, 300);
                1, 2: stall_left <= $urandom_range(1, 5);
                default: stall_left <= 0;
            endcase
        end
    end

    always @(posedge aclk) begin
        stats_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                exp_item = expected_stats.pop_front();
                if (m_running_mean !== exp_item.mean) begin
                    $error("running_mean exp %0d got %0d", exp_item.mean, m_running_mean);
                    fail_count++;
                end
                if (m_running_error !== exp_item.err) begin
                    $error("running_error exp %0d got %0d", exp_item.err, m_running_error);
                    fail_count++;
                end
                if (m_blocks_used !== exp_item.used) begin
                    $error("blocks_used exp %0d got %0d", exp_item.used, m_blocks_used);
                    fail_count++;
                end
                if (m_series_full !== exp_item.full) begin
                    $error("series_full exp %0d got %0d", exp_item.full, m_series_full);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL progressive_block_mean_error");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_block_mean = '0;
        s_block_mean_square = '0;
        s_start_series = 1'b0;
        m_ready = 1'b0;
        fail_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        stall_left = 0;
        run_left = 0;
        held_blocks = 0;
        mean_sum = 0;
        square_sum = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_series_full();
        test_random_series();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_stats.size() == 0)
            $display("PASS progressive_block_mean_error");
        else
            $display("FAIL progressive_block_mean_error");
        $finish;
    end

endmodule
